[rtl/sort_set_ascending_core_defines.svh]
// ----------------------------------------------------------------------------
// sort_set_ascending_core_defines.svh
// Assertion macros used by the sorter core.
// ----------------------------------------------------------------------------
`ifndef SORT_SET_ASCENDING_CORE_DEFINES_SVH
`define SORT_SET_ASCENDING_CORE_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define SSA_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define SSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/ssa_pkg.sv]
// ----------------------------------------------------------------------------
// ssa_pkg
// Types and constants of the ascending set sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package ssa_pkg;

	// Width of one element of the set
	localparam int VALUE_W = 17;

	// Input beat: one element, last marks the end of the set
	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               last;
	} in_item_t;

	// Output beat: one sorted element
	typedef struct packed {
		logic [VALUE_W-1:0] sorted_value;
		logic               end_of_set;
		logic               overflow;
	} out_item_t;

	// Per-cycle command broadcast to every cell
	typedef struct packed {
		logic insert;
		logic shift;
	} ctl_t;

endpackage

`default_nettype wire

[rtl/ssa_stream_if.sv]
// ----------------------------------------------------------------------------
// ssa_stream_if
// Valid/ready stream carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssa_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

[rtl/ssa_cell.sv]
// ----------------------------------------------------------------------------
// ssa_cell
// One slot of the insertion chain: holds a value and its occupancy.
// ----------------------------------------------------------------------------
`default_nettype none

module ssa_cell (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire ssa_pkg::ctl_t                ctl,
	input  wire logic [ssa_pkg::VALUE_W-1:0]  new_value,
	input  wire logic [ssa_pkg::VALUE_W-1:0]  lo_value,
	input  wire logic                         lo_occ,
	input  wire logic                         lo_gt,
	input  wire logic [ssa_pkg::VALUE_W-1:0]  hi_value,
	input  wire logic                         hi_occ,
	output logic [ssa_pkg::VALUE_W-1:0]       value,
	output logic                              occ,
	output logic                              gt
);

	logic [ssa_pkg::VALUE_W-1:0] value_q;
	logic                        occ_q;
	logic [ssa_pkg::VALUE_W-1:0] ins_value;

	// Flag a held value above the incoming one; such cells move up
	assign gt = occ_q && (value_q > new_value);

	// Take the lower neighbor's value if it moves up, else the new value
	assign ins_value = lo_gt ? lo_value : new_value;

	// Occupancy: fill at the end of the chain, follow the upper neighbor on drain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (ctl.shift) begin
			occ_q <= hi_occ;
		end else if (ctl.insert && !occ_q && lo_occ) begin
			occ_q <= 1'b1;
		end
	end

	// Value: shift down on drain, open a gap and insert on a new element
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			value_q <= hi_value;
		end else if (ctl.insert) begin
			if (gt || (!occ_q && lo_occ)) begin
				value_q <= ins_value;
			end
		end
	end

	assign value = value_q;
	assign occ   = occ_q;

endmodule

`default_nettype wire

[rtl/sort_set_ascending_core.sv]
// ----------------------------------------------------------------------------
// sort_set_ascending_core
// Insertion sorter that returns each set of values in ascending order.
// ----------------------------------------------------------------------------
// Usage:
// feed carries one element per beat; last marks the final element of a set.
// While a set is being collected feed takes one beat per cycle: every cell of
// the chain compares its value with the new one and the larger ones move up
// one place, so the chain always stays sorted. Up to MAX_ITEMS elements are
// held; further elements are dropped and overflow is raised on every result
// of that set. After the last beat is taken, feed is held off and the chain
// drains through cell 0 into the result register, one element per cycle
// unless result stalls. The last beat switches the phase register to drain;
// each drain step then loads cell 0 into the result register. end_of_set
// marks the largest element. A stall on result freezes the drain; the chain
// holds its contents. feed reopens once the final result is loaded, even
// while it still waits in the result register. Reset empties the chain and
// the result register; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sort_set_ascending_core_defines.svh"

module sort_set_ascending_core #(
	parameter int MAX_ITEMS = 64
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	ssa_stream_if.sink   feed,
	ssa_stream_if.source result
);

	localparam logic PH_COLLECT = 1'b0;
	localparam logic PH_DRAIN   = 1'b1;

	logic                        phase_q;
	logic                        dropped_q;
	logic                        out_valid_q;
	ssa_pkg::out_item_t          out_q;
	ssa_pkg::ctl_t               ctl;
	logic                        feed_beat;
	logic                        full;
	logic                        take;
	logic [ssa_pkg::VALUE_W-1:0] cell_value [MAX_ITEMS];
	logic [MAX_ITEMS-1:0]        cell_occ;
	logic [MAX_ITEMS-1:0]        cell_gt;

	// Decode handshakes and broadcast the cell command
	assign feed_beat  = feed.valid && feed.ready;
	assign full       = cell_occ[MAX_ITEMS-1];
	assign take       = (phase_q == PH_DRAIN) && (!out_valid_q || result.ready);
	assign ctl.insert = feed_beat && !full;
	assign ctl.shift  = take;
	assign feed.ready = (phase_q == PH_COLLECT);

	// Build the chain; cell 0 faces the output
	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
		logic [ssa_pkg::VALUE_W-1:0] lo_value;
		logic                        lo_occ;
		logic                        lo_gt;
		logic [ssa_pkg::VALUE_W-1:0] hi_value;
		logic                        hi_occ;

		if (i == 0) begin : g_bottom
			assign lo_value = '0;
			assign lo_occ   = 1'b1;
			assign lo_gt    = 1'b0;
		end else begin : g_lower
			assign lo_value = cell_value[i-1];
			assign lo_occ   = cell_occ[i-1];
			assign lo_gt    = cell_gt[i-1];
		end

		if (i == MAX_ITEMS - 1) begin : g_top
			assign hi_value = '0;
			assign hi_occ   = 1'b0;
		end else begin : g_upper
			assign hi_value = cell_value[i+1];
			assign hi_occ   = cell_occ[i+1];
		end

		ssa_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.new_value (feed.payload.value),
			.lo_value  (lo_value),
			.lo_occ    (lo_occ),
			.lo_gt     (lo_gt),
			.hi_value  (hi_value),
			.hi_occ    (hi_occ),
			.value     (cell_value[i]),
			.occ       (cell_occ[i]),
			.gt        (cell_gt[i])
		);
	end

	// Advance between collecting and draining; track dropped elements
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_COLLECT;
			dropped_q <= 1'b0;
		end else begin
			unique case (phase_q)
				PH_COLLECT: begin
					if (feed_beat && full) begin
						dropped_q <= 1'b1;
					end
					if (feed_beat && feed.payload.last) begin
						phase_q <= PH_DRAIN;
					end
				end
				PH_DRAIN: begin
					if (take && !cell_occ[1]) begin
						phase_q   <= PH_COLLECT;
						dropped_q <= 1'b0;
					end
				end
				default: begin
					phase_q <= PH_COLLECT;
				end
			endcase
		end
	end

	// Hold the result beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load the bottom cell into the result register
	always_ff @(posedge clk) begin
		if (take) begin
			out_q.sorted_value <= cell_value[0];
			out_q.end_of_set   <= !cell_occ[1];
			out_q.overflow     <= dropped_q;
		end
	end

	assign result.valid   = out_valid_q;
	assign result.payload = out_q;

	// Occupied cells form a contiguous run from cell 0
	`SSA_ASSERT_SAME(a_occ_run, clk, arst_n, 1'b1, ((cell_occ >> 1) & ~cell_occ) == '0, "gap in chain")
	// A set being drained always has an element in cell 0
	`SSA_ASSERT_SAME(a_drain_nonempty, clk, arst_n, phase_q == PH_DRAIN, cell_occ[0], "drain on empty chain")
	// The last beat starts the drain
	`SSA_ASSERT_NEXT(a_last_drains, clk, arst_n, feed_beat && feed.payload.last, phase_q == PH_DRAIN, "no drain after last")
	// Loading the final element leaves the chain empty and reopens feed
	`SSA_ASSERT_NEXT(a_drain_done, clk, arst_n, take && !cell_occ[1], (phase_q == PH_COLLECT) && (cell_occ == '0) && out_q.end_of_set, "drain did not finish")

endmodule

`default_nettype wire
